/* rtl/sd64_pkg.sv */
// Shared constants and the command bundle for the saturating 64-by-32 divider.
package sd64_pkg;

	// Quotient and divisor width; the dividend is twice as wide.
	localparam int unsigned QW = 32;
	localparam int unsigned NW = 2 * QW;
	// Step counter width for the iterative divider.
	localparam int unsigned CNT_W = $clog2(QW);

	// Tdata widths, packed without gaps and filled up to whole bytes.
	localparam int unsigned IN_TDATA_W  = ((NW + QW + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((QW + 7) / 8) * 8;

	// Division modes carried on the input tuser.
	localparam logic KIND_UNSIGNED = 1'b0;
	localparam logic KIND_SIGNED   = 1'b1;

	// Saturation and special-case results.
	localparam logic [QW-1:0] Q_ALL_ONES = {QW{1'b1}};
	localparam logic [QW-1:0] Q_POS_LIM  = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] Q_NEG_LIM  = {1'b1, {(QW-1){1'b0}}};
	localparam logic [QW-1:0] Q_ONE      = {{(QW-1){1'b0}}, 1'b1};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture magnitudes and flags of an accepted beat
		logic check;  // compare the upper dividend half with the divisor
		logic step;   // one restoring division step
		logic finish; // apply sign and saturation into the output register
	} sd64_cmd_t;

endpackage

/* rtl/sd64_dp.sv */
// Datapath of the saturating divider: operand magnitudes, radix-2 restoring loop, result fix-up.
module sd64_dp
	import sd64_pkg::*;
(
	input  logic                   clk,
	input  sd64_cmd_t              cmd,
	input  logic                   kind,
	input  logic [NW-1:0]          dividend_bits,
	input  logic [QW-1:0]          divisor_bits,
	output logic [QW-1:0]          quotient_bits
);

	logic          kind_q;
	logic          num_neg_q;
	logic          den_neg_q;
	logic          num_zero_q;
	logic          den_zero_q;
	logic          ovf_q;
	logic [QW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] den_q;
	logic [QW-1:0] quot_q;

	logic          num_neg;
	logic          den_neg;
	logic [NW-1:0] num_mag;
	logic [QW-1:0] den_mag;
	logic [QW:0]   trial;
	logic          fits;
	logic [QW:0]   diff;
	logic          big;
	logic [QW-1:0] result;

	// Sign detection and magnitudes of the incoming operands.
	always_comb begin
		num_neg = (kind == KIND_SIGNED) && dividend_bits[NW-1];
		den_neg = (kind == KIND_SIGNED) && divisor_bits[QW-1];
		num_mag = num_neg ? (~dividend_bits + NW'(1)) : dividend_bits;
		den_mag = den_neg ? (~divisor_bits + QW'(1)) : divisor_bits;
	end

	// One restoring step: shift in the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, lo_q[QW-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// Sign and saturation of the finished quotient; lo_q holds its magnitude.
	always_comb begin
		big = ovf_q || lo_q[QW-1];
		if (den_zero_q) begin
			if (kind_q == KIND_SIGNED) begin
				result = num_neg_q ? Q_NEG_LIM : Q_POS_LIM;
			end else begin
				result = num_zero_q ? Q_ONE : Q_ALL_ONES;
			end
		end else if (kind_q == KIND_UNSIGNED) begin
			result = ovf_q ? Q_ALL_ONES : lo_q;
		end else if (num_neg_q != den_neg_q) begin
			// A magnitude of exactly the negative limit also lands on the limit.
			result = big ? Q_NEG_LIM : (~lo_q + QW'(1));
		end else begin
			result = big ? Q_POS_LIM : lo_q;
		end
	end

	// Operand, remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			num_neg_q  <= num_neg;
			den_neg_q  <= den_neg;
			num_zero_q <= dividend_bits == '0;
			den_zero_q <= divisor_bits == '0;
			rem_q      <= num_mag[NW-1:QW];
			lo_q       <= num_mag[QW-1:0];
			den_q      <= den_mag;
		end
		if (cmd.check) begin
			ovf_q <= rem_q >= den_q;
		end
		if (cmd.step) begin
			rem_q <= fits ? diff[QW-1:0] : trial[QW-1:0];
			lo_q  <= {lo_q[QW-2:0], fits};
		end
		if (cmd.finish) begin
			quot_q <= result;
		end
	end

	assign quotient_bits = quot_q;

endmodule

/* rtl/sd64_ctrl.sv */
// Controller of the saturating divider: beat handshakes, step sequencing and output valid.
module sd64_ctrl
	import sd64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output sd64_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	// The output register can take a result when empty or being drained.
	assign out_free = !out_valid_q || m_tready;

	assign s_tready   = state_q == ST_IDLE;
	assign m_tvalid   = out_valid_q;
	assign cmd.load   = s_tvalid && (state_q == ST_IDLE);
	assign cmd.check  = state_q == ST_CHECK;
	assign cmd.step   = state_q == ST_DIV;
	assign cmd.finish = (state_q == ST_DONE) && out_free;

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// An accepted beat always moves straight on to the overflow check.
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_CHECK))
		else $error("accepted beat did not start the check");

	// A result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.finish)
		else $error("result overwritten before it was taken");

	// Finishing always presents a result in the next cycle.
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (m_tvalid && (state_q == ST_IDLE)))
		else $error("finished result not presented");

	// The loop ends only after the last quotient bit.
	a_loop_length: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && (cnt_q != CNT_W'(QW - 1))) |=> (state_q == ST_DIV))
		else $error("division loop left early");
`endif

endmodule

/* rtl/saturating_divide_64_by_32.sv */
// Each input beat is accepted in the idle state and then passes through the overflow check,
// the 32 steps of the radix-2 restoring loop and the result fix-up; only then is the next
// input beat accepted, so one division is in progress at a time.
// A waiting result does not block the next input beat; the loop stalls only at the end
// while the output register is still full.
// Reset (arst_n, asynchronous, active low) clears the controller and the output valid.
module saturating_divide_64_by_32
	import sd64_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [63:0] dividend_bits, [95:64] divisor_bits
	input  logic                   s_tuser,  // [0] kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // [31:0] quotient_bits
);

	sd64_cmd_t     cmd;
	logic [QW-1:0] quotient_bits;

	// Sequencing and handshakes.
	sd64_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic.
	sd64_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.kind          (s_tuser),
		.dividend_bits (s_tdata[NW-1:0]),
		.divisor_bits  (s_tdata[NW+QW-1:NW]),
		.quotient_bits (quotient_bits)
	);

	assign m_tdata = OUT_TDATA_W'(quotient_bits);

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the saturating 64-by-32 divider stream block.
`timescale 1ns / 1ps

module testbench;
	import sd64_pkg::*;

	// Cycles without any accepted beat before the run is abandoned.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles waited after the last quotient before the verdict.
	localparam int unsigned DRAIN_CYCLES = 40;
	// Length of the receiver's long hold-off, and the quotients at which it starts.
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned HOLD_OFF_FIRST = 40;
	localparam int unsigned HOLD_OFF_SECOND = 1200;
	localparam int unsigned RANDOM_DIVISIONS = 1800;
	localparam int unsigned MID_RUN_PAUSE = 900;
	localparam int unsigned MAX_GAP = 17;

	// One division request as carried on the input stream.
	typedef struct packed {
		logic          kind;
		logic [NW-1:0] dividend;
		logic [QW-1:0] divisor;
	} division_t;

	// A directed row; the quotient is used only where it is marked as known.
	typedef struct packed {
		logic          kind;
		logic [NW-1:0] dividend;
		logic [QW-1:0] divisor;
		logic          known;
		logic [QW-1:0] quotient;
	} directed_row_t;

	// A division awaiting its quotient on the output stream.
	typedef struct packed {
		division_t     request;
		logic [QW-1:0] quotient;
	} awaited_t;

	// Shapes of random operands.
	typedef enum logic [2:0] {
		SHAPE_RAW,
		SHAPE_EXACT,
		SHAPE_ZERO_DIVISOR,
		SHAPE_UNIT_DIVISOR,
		SHAPE_NARROW,
		SHAPE_LIMIT_QUOTIENT,
		SHAPE_CORNER
	} operand_shape_t;

	localparam int unsigned DIRECTED_ROWS = 24;

	// Extremes, zero divisors, overflow on both sides and truncation towards zero.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{KIND_UNSIGNED, 64'd0, 32'd0, 1'b1, Q_ONE},
		'{KIND_UNSIGNED, 64'd5, 32'd0, 1'b1, Q_ALL_ONES},
		'{KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, Q_ALL_ONES},
		'{KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b1, Q_ALL_ONES},
		'{KIND_UNSIGNED, 64'h0000_0000_FFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFF},
		'{KIND_UNSIGNED, 64'h0000_0001_0000_0000, 32'd1, 1'b1, Q_ALL_ONES},
		'{KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{KIND_UNSIGNED, 64'hFFFF_FFFE_0000_0001, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{KIND_UNSIGNED, 64'd100, 32'd7, 1'b0, 32'd0},
		'{KIND_UNSIGNED, 64'd0, 32'hFFFF_FFFF, 1'b1, 32'd0},
		'{KIND_SIGNED, 64'd0, 32'd0, 1'b1, Q_POS_LIM},
		'{KIND_SIGNED, 64'd5, 32'd0, 1'b1, Q_POS_LIM},
		'{KIND_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, Q_NEG_LIM},
		'{KIND_SIGNED, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1, Q_POS_LIM},
		'{KIND_SIGNED, 64'h8000_0000_0000_0000, 32'd1, 1'b1, Q_NEG_LIM},
		'{KIND_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1, 1'b1, Q_POS_LIM},
		'{KIND_SIGNED, 64'hFFFF_FFFF_8000_0000, 32'd1, 1'b0, 32'd0},
		'{KIND_SIGNED, 64'h0000_0000_8000_0000, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{KIND_SIGNED, 64'h0000_0000_8000_0000, 32'd1, 1'b0, 32'd0},
		'{KIND_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 32'd2, 1'b0, 32'd0},
		'{KIND_SIGNED, 64'd7, 32'hFFFF_FFFE, 1'b0, 32'd0},
		'{KIND_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 32'hFFFF_FFFE, 1'b0, 32'd0},
		'{KIND_SIGNED, 64'd0, 32'h8000_0000, 1'b1, 32'd0},
		'{KIND_SIGNED, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, 32'd0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;  // [63:0] dividend_bits, [95:64] divisor_bits
	logic                   s_tuser = 1'b0; // [0] kind
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;       // [31:0] quotient_bits

	awaited_t    awaited_quotients [$];
	int unsigned mismatch_count = 0;
	int unsigned quotients_seen = 0;
	int unsigned divisions_sent = 0;
	bit          sender_calm = 1'b0;

	saturating_divide_64_by_32 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Prints one line per mismatch and keeps count.
	task automatic report(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Saturated quotient for the given mode and operands.
	function automatic logic [QW-1:0] saturated_quotient(input division_t req);
		logic          dividend_neg;
		logic          divisor_neg;
		logic [NW-1:0] dividend_mag;
		logic [NW-1:0] divisor_mag;
		logic [QW-1:0] divisor_neg_bits;
		logic [NW-1:0] ratio;
		dividend_neg = req.dividend[NW-1];
		divisor_neg = req.divisor[QW-1];
		if (req.kind == KIND_UNSIGNED) begin
			if (req.divisor == '0)
				return (req.dividend == '0) ? Q_ONE : Q_ALL_ONES;
			ratio = req.dividend / {{QW{1'b0}}, req.divisor};
			return (ratio[NW-1:QW] != '0) ? Q_ALL_ONES : ratio[QW-1:0];
		end
		if (req.divisor == '0)
			return dividend_neg ? Q_NEG_LIM : Q_POS_LIM;
		// Magnitudes; the most negative dividend wraps onto itself, which reads as 2^63.
		dividend_mag = dividend_neg ? -req.dividend : req.dividend;
		divisor_neg_bits = -req.divisor;
		divisor_mag = {{QW{1'b0}}, divisor_neg ? divisor_neg_bits : req.divisor};
		ratio = dividend_mag / divisor_mag;
		if (dividend_neg != divisor_neg) begin
			if (ratio >= {{QW{1'b0}}, Q_NEG_LIM})
				return Q_NEG_LIM;
			return -ratio[QW-1:0];
		end
		return (ratio > {{QW{1'b0}}, Q_POS_LIM}) ? Q_POS_LIM : ratio[QW-1:0];
	endfunction

	// Random operands, weighted towards shapes that reach both saturation and exact results.
	function automatic division_t random_division();
		division_t      req;
		operand_shape_t shape;
		int unsigned    pick;
		logic [QW-1:0]  den;
		logic [QW-1:0]  quo;
		logic [NW-1:0]  near_limit;
		logic [NW-1:0]  corner_dividends [4];
		logic [QW-1:0]  corner_divisors [5];
		corner_dividends = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF};
		corner_divisors = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		pick = $urandom_range(0, 19);
		shape = (pick < 4) ? SHAPE_RAW :
			(pick < 10) ? SHAPE_EXACT :
			(pick < 11) ? SHAPE_ZERO_DIVISOR :
			(pick < 13) ? SHAPE_UNIT_DIVISOR :
			(pick < 15) ? SHAPE_NARROW :
			(pick < 18) ? SHAPE_LIMIT_QUOTIENT : SHAPE_CORNER;
		req.kind = $urandom_range(0, 1) ? KIND_SIGNED : KIND_UNSIGNED;
		req.dividend = {$urandom(), $urandom()};
		req.divisor = $urandom();
		den = $urandom() >> $urandom_range(0, QW - 1);
		if (den == '0)
			den = 32'd1;
		quo = $urandom() >> $urandom_range(0, QW - 1);
		case (shape)
			SHAPE_EXACT: begin
				req.divisor = den;
				req.dividend = {{QW{1'b0}}, quo} * {{QW{1'b0}}, den} + ($urandom() % den);
			end
			SHAPE_ZERO_DIVISOR: begin
				req.divisor = '0;
				req.dividend = req.dividend >> $urandom_range(0, NW - 1);
			end
			SHAPE_UNIT_DIVISOR: begin
				req.divisor = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
			end
			SHAPE_NARROW: begin
				req.dividend = req.dividend >> $urandom_range(0, NW - 1);
				req.divisor = req.divisor >> $urandom_range(0, QW - 1);
			end
			SHAPE_LIMIT_QUOTIENT: begin
				near_limit = $urandom_range(0, 1) ? 64'h0000_0000_8000_0000
					: 64'h0000_0001_0000_0000;
				near_limit = near_limit + $urandom_range(0, 2) - 1;
				req.divisor = den;
				req.dividend = near_limit * {{QW{1'b0}}, den} + ($urandom() % den);
			end
			SHAPE_CORNER: begin
				req.dividend = corner_dividends[$urandom_range(0, 3)];
				req.divisor = corner_divisors[$urandom_range(0, 4)];
			end
			default: begin
			end
		endcase
		// In signed mode, flip signs at random so that every sign pairing turns up.
		if (req.kind == KIND_SIGNED && shape != SHAPE_RAW && shape != SHAPE_CORNER) begin
			if ($urandom_range(0, 1))
				req.dividend = -req.dividend;
			if ($urandom_range(0, 1))
				req.divisor = -req.divisor;
		end
		return req;
	endfunction

	// Offers one beat after a random gap and records its quotient once accepted.
	task automatic send_division(input division_t req, input logic known,
			input logic [QW-1:0] known_quotient);
		int unsigned gap;
		awaited_t    entry;
		if (divisions_sent % 64 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
		gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {req.divisor, req.dividend};
		s_tuser <= req.kind;
		do @(posedge clk); while (!s_tready);
		entry.request = req;
		entry.quotient = known ? known_quotient : saturated_quotient(req);
		awaited_quotients.push_back(entry);
		divisions_sent++;
	endtask

	// Withdraws the beat and waits until every quotient in flight has arrived.
	task automatic drain_quotients();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_quotients.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls per beat, calm stretches, and two long hold-offs.
	initial begin : receiver
		int unsigned stall;
		int unsigned beats;
		bit          calm;
		beats = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			if (beats % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (quotients_seen == HOLD_OFF_FIRST || quotients_seen == HOLD_OFF_SECOND)
				stall = HOLD_OFF_CYCLES;
			else
				stall = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			beats++;
		end
	end

	// Compares each output beat with the oldest quotient awaited.
	always @(posedge clk) begin
		awaited_t entry;
		if (arst_n && m_tvalid && m_tready) begin
			quotients_seen++;
			if (awaited_quotients.size() == 0) begin
				report($sformatf("quotient %h arrived with none awaited", m_tdata[QW-1:0]));
			end else begin
				entry = awaited_quotients.pop_front();
				if (m_tdata[QW-1:0] !== entry.quotient)
					report($sformatf("kind %0b %h / %h: quotient %h, expected %h",
						entry.request.kind, entry.request.dividend, entry.request.divisor,
						m_tdata[QW-1:0], entry.quotient));
			end
		end
	end

	// Ends the run when no beat moves on either side for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("testbench failed");
		$finish;
	end

	// Reset, directed table, random divisions, then the verdict.
	initial begin : sender
		division_t req;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			req.kind = directed_rows[row].kind;
			req.dividend = directed_rows[row].dividend;
			req.divisor = directed_rows[row].divisor;
			send_division(req, directed_rows[row].known, directed_rows[row].quotient);
		end
		drain_quotients();

		for (int n = 1; n <= RANDOM_DIVISIONS; n++) begin
			if (n == MID_RUN_PAUSE)
				drain_quotients();
			send_division(random_division(), 1'b0, '0);
		end
		drain_quotients();

		// Give a stray beat time to show itself before the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		foreach (awaited_quotients[i])
			report($sformatf("quotient %h never arrived", awaited_quotients[i].quotient));
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
